// ===== rtl/drivetrain_acceleration_limiter_core_assert.svh =====
// Assertion macros for the drivetrain acceleration limiter checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef DRIVETRAIN_ACCELERATION_LIMITER_CORE_ASSERT_SVH
`define DRIVETRAIN_ACCELERATION_LIMITER_CORE_ASSERT_SVH

// same-cycle implication
`define DAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DAL_ASSERT_THEN(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dal_pkg.sv =====
// Shared types and constants of the drivetrain acceleration limiter.
// No dependencies; used by dal_mul, dal_div, the core and the testbench.
package dal_pkg;

    localparam int DAL_MAX_GEARS = 8;

    localparam int DAL_NUM_W  = 58;
    localparam int DAL_DEN_W  = 40;
    localparam int DAL_MA_W   = 58;
    localparam int DAL_MB_W   = 16;
    localparam int DAL_PROD_W = DAL_MA_W + DAL_MB_W;
    localparam int DAL_CNT_W  = $clog2(DAL_NUM_W);

    localparam logic [17:0] DAL_PI_Q16      = 18'd205887;
    localparam logic [13:0] DAL_ONE_G_MM    = 14'd9810;
    localparam logic [15:0] DAL_RPM_SCALE   = 16'd60000;
    localparam logic [13:0] DAL_WHEEL_SCALE = 14'd15625;
    localparam logic [9:0]  DAL_DRAG_SCALE  = 10'd1000;
    localparam logic [12:0] DAL_TORQUE_REF  = 13'd5000;
    localparam logic [15:0] DAL_CURVE_RPM1  = 16'd1350;
    localparam logic [15:0] DAL_CURVE_RPM2  = 16'd4600;
    localparam logic [15:0] DAL_CURVE_RPM3  = 16'd5000;

    localparam logic [3:0]  DAL_RST_GEAR_COUNT = 4'd6;
    localparam logic [63:0] DAL_RST_GEAR_RATIOS = 64'd0;
    localparam logic [15:0] DAL_RST_AXLE = 16'd16384;
    localparam logic [10:0] DAL_RST_WHEEL = 11'd650;
    localparam logic [15:0] DAL_RST_MASS = 16'd1500;
    localparam logic [11:0] DAL_RST_TORQUE = 12'd300;
    localparam logic [31:0] DAL_RST_WINDOW = 32'd458753000;
    localparam logic [47:0] DAL_RST_RESIST = 48'd0;

    typedef enum logic [2:0] {
        CFG_GEAR_COUNT  = 3'd0,
        CFG_GEAR_RATIOS = 3'd1,
        CFG_AXLE_RATIO  = 3'd2,
        CFG_WHEEL_DIAM  = 3'd3,
        CFG_MASS        = 3'd4,
        CFG_MAX_TORQUE  = 3'd5,
        CFG_RPM_WINDOW  = 3'd6,
        CFG_RESISTANCE  = 3'd7
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LO_A, ST_LO_B, ST_LO_C, ST_TQ4, ST_TQ4_W, ST_DEN_A, ST_DEN_B,
        ST_GEAR, ST_G_M1, ST_G_M2, ST_G_M3, ST_G_DIV, ST_CURVE, ST_INT_M,
        ST_INT_DIV, ST_TQG, ST_TQG2, ST_FIN, ST_FW_M1, ST_FW_M2, ST_FW_DIV,
        ST_FA_M1, ST_FA_M2, ST_FA_M3, ST_NET_DIV, ST_CLAMP
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DAL_NUM_W-1:0] num;
        logic [DAL_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DAL_NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== rtl/dal_mul.sv =====
// Shared registered multiplier of the acceleration limiter.
// Depends on dal_pkg for operand widths.
module dal_mul (
    input  logic                           clk,
    input  logic [dal_pkg::DAL_MA_W-1:0]   a,
    input  logic [dal_pkg::DAL_MB_W-1:0]   b,
    output logic [dal_pkg::DAL_PROD_W-1:0] p
);
    import dal_pkg::*;

    logic [DAL_PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= DAL_PROD_W'(a) * DAL_PROD_W'(b);
    end

    assign p = p_reg;

endmodule

// ===== rtl/dal_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on dal_pkg for the request and response structs.
module dal_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dal_pkg::div_req_t req,
    output dal_pkg::div_rsp_t rsp
);
    import dal_pkg::*;

    logic [DAL_NUM_W-1:0] num_reg, num_next;
    logic [DAL_DEN_W-1:0] rem_reg, rem_next;
    logic [DAL_DEN_W-1:0] den_reg, den_next;
    logic [DAL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DAL_DEN_W:0]   shifted;
    logic [DAL_DEN_W:0]   diff;
    logic                 fits;

    always_comb
    begin
        shifted   = {rem_reg, num_reg[DAL_NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        fits      = shifted >= {1'b0, den_reg};
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = DAL_CNT_W'(DAL_NUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DAL_NUM_W-2:0], fits};
            rem_next = fits ? diff[DAL_DEN_W-1:0] : shifted[DAL_DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;

endmodule

// ===== rtl/drivetrain_acceleration_limiter_core.sv =====
// Drivetrain acceleration limiter: configuration registers and sequencer.
// Depends on dal_pkg, dal_mul and dal_div.
//
//   channel | signals                                          | role
//   in      | in_valid in_ready acting requested_accel         | request
//           | vehicle_speed road_friction                      |
//   out     | out_valid out_ready limited_accel acting_out     | result
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data           | register write
//
// A request runs longer the more gears are in use; every division holds the sequencer
// until the one shared divider is done.
// Reset loads the register defaults and clears the held acceleration.
// in_ready is high only while the sequencer is idle; a stalled result waits in
// the output register and the next request is already taken meanwhile.
module drivetrain_acceleration_limiter_core #(
    parameter int MAX_GEARS = dal_pkg::DAL_MAX_GEARS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               acting,
    input  logic signed [17:0] requested_accel,
    input  logic [15:0]        vehicle_speed,
    input  logic [9:0]         road_friction,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [17:0] limited_accel,
    output logic               acting_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import dal_pkg::*;

    state_t state_reg, state_next;

    logic [3:0]  gear_count_reg;
    logic [63:0] gear_ratios_reg;
    logic [15:0] axle_reg;
    logic [10:0] wheel_reg;
    logic [15:0] mass_reg;
    logic [11:0] torque_reg;
    logic [31:0] window_reg;
    logic [47:0] resist_reg;

    logic signed [17:0] held_reg, held_next;
    logic [15:0] v_reg, v_next;
    logic [9:0]  rf_reg, rf_next;
    logic        act_reg, act_next;
    logic [23:0] lo_reg, lo_next;
    logic [32:0] tq4_reg, tq4_next;
    logic [36:0] rden_reg, rden_next;
    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  g_reg, g_next;
    logic [15:0] rpm_reg, rpm_next;
    logic        found_reg, found_next;
    logic [40:0] best_reg, best_next;
    logic [32:0] tq_reg, tq_next;
    logic [32:0] base_reg, base_next;
    logic        neg_reg, neg_next;
    logic [15:0] span_reg, span_next;
    logic [53:0] fw_reg, fw_next;
    logic signed [25:0] hi_reg, hi_next;
    logic        out_valid_reg, out_valid_next;
    logic signed [17:0] out_accel_reg, out_accel_next;
    logic        out_act_reg, out_act_next;

    logic [DAL_MA_W-1:0]   mul_a;
    logic [DAL_MB_W-1:0]   mul_b;
    logic [DAL_PROD_W-1:0] mul_p;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [10:0] d_eff;
    logic [15:0] m_eff;
    logic [15:0] rmin, rmax;
    logic [3:0]  n_eff;
    logic [32:0] tq0, tqf;
    logic [2:0]  seg;
    logic [15:0] sp_hi, sp_lo;
    logic [32:0] tq_hi, tq_lo;
    logic [16:0] span17;
    logic [33:0] dtq;
    logic [32:0] dmag;
    logic [40:0] gq;
    logic [33:0] fa;
    logic signed [55:0] net;
    logic [55:0] net_mag;
    logic signed [57:0] quot_s, hi58;
    logic signed [25:0] held_w, lo_w, r1, r2;
    logic        out_free;

    dal_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    dal_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign limited_accel = out_accel_reg;
    assign acting_out    = out_act_reg;

    always_comb
    begin
        d_eff = (wheel_reg == '0) ? 11'd1 : wheel_reg;
        m_eff = (mass_reg == '0) ? 16'd1 : mass_reg;
        rmin  = window_reg[15:0];
        rmax  = window_reg[31:16];
        n_eff = (gear_count_reg > 4'(MAX_GEARS)) ? 4'(MAX_GEARS) : gear_count_reg;
        tq0   = {14'd0, torque_reg, 7'd0};
        tqf   = {13'd0, torque_reg, 8'd0};

        seg = 3'd4;
        if (rmax >= rpm_reg)           seg = 3'd4;
        if (DAL_CURVE_RPM3 >= rpm_reg) seg = 3'd3;
        if (DAL_CURVE_RPM2 >= rpm_reg) seg = 3'd2;
        if (DAL_CURVE_RPM1 >= rpm_reg) seg = 3'd1;
        case (seg)
            3'd1:
            begin
                sp_hi = DAL_CURVE_RPM1; sp_lo = rmin;
                tq_hi = tqf; tq_lo = tq0;
            end
            3'd2:
            begin
                sp_hi = DAL_CURVE_RPM2; sp_lo = DAL_CURVE_RPM1;
                tq_hi = tqf; tq_lo = tqf;
            end
            3'd3:
            begin
                sp_hi = DAL_CURVE_RPM3; sp_lo = DAL_CURVE_RPM2;
                tq_hi = tqf; tq_lo = tqf;
            end
            default:
            begin
                sp_hi = rmax; sp_lo = DAL_CURVE_RPM3;
                tq_hi = tq4_reg; tq_lo = tqf;
            end
        endcase
        span17 = {1'b0, sp_hi} - {1'b0, sp_lo};
        dtq    = {1'b0, tq_hi} - {1'b0, tq_lo};
        dmag   = dtq[33] ? 33'(-dtq) : dtq[32:0];

        gq      = mul_p[40:0];
        fa      = mul_p[57:24];
        net     = $signed({2'b00, fw_reg}) - $signed({22'd0, fa});
        net_mag = net[55] ? 56'(-net) : 56'(net);
        quot_s  = neg_reg ? -$signed(div_rsp.quot) : $signed(div_rsp.quot);
        hi58    = quot_s - $signed({42'd0, resist_reg[15:0]});

        held_w = 26'(held_reg);
        lo_w   = -$signed({2'b00, lo_reg});
        r1     = (held_w < hi_reg) ? held_w : hi_reg;
        r2     = (r1 < lo_w) ? lo_w : r1;
        out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        v_next         = v_reg;
        rf_next        = rf_reg;
        act_next       = act_reg;
        lo_next        = lo_reg;
        tq4_next       = tq4_reg;
        rden_next      = rden_reg;
        idx_next       = idx_reg;
        g_next         = g_reg;
        rpm_next       = rpm_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        tq_next        = tq_reg;
        base_next      = base_reg;
        neg_next       = neg_reg;
        span_next      = span_reg;
        fw_next        = fw_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_accel_next = out_accel_reg;
        out_act_next   = out_act_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_req.start  = 1'b0;
        div_req.num    = '0;
        div_req.den    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    v_next   = vehicle_speed;
                    rf_next  = road_friction;
                    act_next = acting;
                    if (acting)
                    begin
                        held_next = requested_accel;
                    end
                    state_next = ST_LO_A;
                end
            end
            ST_LO_A:
            begin
                mul_a      = DAL_MA_W'(rf_reg);
                mul_b      = resist_reg[47:32];
                state_next = ST_LO_B;
            end
            ST_LO_B:
            begin
                mul_a      = mul_p[DAL_MA_W-1:0];
                mul_b      = DAL_MB_W'(DAL_ONE_G_MM);
                state_next = ST_LO_C;
            end
            ST_LO_C:
            begin
                lo_next    = mul_p[39:16];
                mul_a      = DAL_MA_W'(torque_reg);
                mul_b      = DAL_MB_W'(DAL_TORQUE_REF);
                state_next = ST_TQ4;
            end
            ST_TQ4:
            begin
                if (rmax == '0)
                begin
                    tq4_next   = '0;
                    state_next = ST_DEN_A;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = DAL_NUM_W'({mul_p[24:0], 8'd0});
                    div_req.den   = DAL_DEN_W'(rmax);
                    state_next    = ST_TQ4_W;
                end
            end
            ST_TQ4_W:
            begin
                if (div_rsp.done)
                begin
                    tq4_next   = div_rsp.quot[32:0];
                    state_next = ST_DEN_A;
                end
            end
            ST_DEN_A:
            begin
                mul_a      = DAL_MA_W'(DAL_PI_Q16);
                mul_b      = DAL_MB_W'(d_eff);
                state_next = ST_DEN_B;
            end
            ST_DEN_B:
            begin
                rden_next  = {mul_p[28:0], 8'd0};
                idx_next   = '0;
                found_next = 1'b0;
                best_next  = '0;
                state_next = ST_GEAR;
            end
            ST_GEAR:
            begin
                g_next = gear_ratios_reg[{idx_reg[2:0], 3'b000} +: 8];
                mul_a  = DAL_MA_W'(v_reg);
                mul_b  = axle_reg;
                state_next = (idx_reg >= n_eff) ? ST_FIN : ST_G_M1;
            end
            ST_G_M1:
            begin
                mul_a      = mul_p[DAL_MA_W-1:0];
                mul_b      = DAL_MB_W'(g_reg);
                state_next = ST_G_M2;
            end
            ST_G_M2:
            begin
                mul_a      = mul_p[DAL_MA_W-1:0];
                mul_b      = DAL_RPM_SCALE;
                state_next = ST_G_M3;
            end
            ST_G_M3:
            begin
                div_req.start = 1'b1;
                div_req.num   = DAL_NUM_W'(mul_p[55:0]);
                div_req.den   = DAL_DEN_W'(rden_reg);
                state_next    = ST_G_DIV;
            end
            ST_G_DIV:
            begin
                if (div_rsp.done)
                begin
                    rpm_next = div_rsp.quot[15:0];
                    if ((div_rsp.quot > DAL_NUM_W'(rmax)) || (div_rsp.quot < DAL_NUM_W'(rmin)))
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_GEAR;
                    end
                    else
                    begin
                        state_next = ST_CURVE;
                    end
                end
            end
            ST_CURVE:
            begin
                base_next = tq_lo;
                neg_next  = dtq[33];
                span_next = span17[15:0];
                mul_a     = DAL_MA_W'(dmag);
                mul_b     = rpm_reg - sp_lo;
                if (rpm_reg <= rmin)
                begin
                    tq_next    = tq0;
                    state_next = ST_TQG;
                end
                else if (rpm_reg >= rmax)
                begin
                    tq_next    = tq4_reg;
                    state_next = ST_TQG;
                end
                else if (span17[16] || (span17 == '0))
                begin
                    tq_next    = tq_hi;
                    state_next = ST_TQG;
                end
                else
                begin
                    state_next = ST_INT_M;
                end
            end
            ST_INT_M:
            begin
                div_req.start = 1'b1;
                div_req.num   = mul_p[DAL_NUM_W-1:0];
                div_req.den   = DAL_DEN_W'(span_reg);
                state_next    = ST_INT_DIV;
            end
            ST_INT_DIV:
            begin
                if (div_rsp.done)
                begin
                    tq_next = neg_reg ? (base_reg - div_rsp.quot[32:0])
                                      : (base_reg + div_rsp.quot[32:0]);
                    state_next = ST_TQG;
                end
            end
            ST_TQG:
            begin
                mul_a      = DAL_MA_W'(tq_reg);
                mul_b      = DAL_MB_W'(g_reg);
                state_next = ST_TQG2;
            end
            ST_TQG2:
            begin
                if (!found_reg || (gq > best_reg))
                begin
                    best_next = gq;
                end
                found_next = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_GEAR;
            end
            ST_FIN:
            begin
                mul_a = DAL_MA_W'(best_reg);
                mul_b = axle_reg;
                if (!found_reg)
                begin
                    hi_next    = 26'(DAL_ONE_G_MM);
                    state_next = ST_CLAMP;
                end
                else
                begin
                    state_next = ST_FW_M1;
                end
            end
            ST_FW_M1:
            begin
                mul_a      = mul_p[DAL_MA_W-1:0];
                mul_b      = DAL_MB_W'(DAL_WHEEL_SCALE);
                state_next = ST_FW_M2;
            end
            ST_FW_M2:
            begin
                div_req.start = 1'b1;
                div_req.num   = DAL_NUM_W'(mul_p[70:17]);
                div_req.den   = DAL_DEN_W'(d_eff);
                state_next    = ST_FW_DIV;
            end
            ST_FW_DIV:
            begin
                mul_a = DAL_MA_W'(resist_reg[31:16]);
                mul_b = v_reg;
                if (div_rsp.done)
                begin
                    fw_next    = div_rsp.quot[53:0];
                    state_next = ST_FA_M1;
                end
            end
            ST_FA_M1:
            begin
                mul_a      = mul_p[DAL_MA_W-1:0];
                mul_b      = v_reg;
                state_next = ST_FA_M2;
            end
            ST_FA_M2:
            begin
                mul_a      = mul_p[DAL_MA_W-1:0];
                mul_b      = DAL_MB_W'(DAL_DRAG_SCALE);
                state_next = ST_FA_M3;
            end
            ST_FA_M3:
            begin
                neg_next      = net[55];
                div_req.start = 1'b1;
                div_req.num   = DAL_NUM_W'(net_mag);
                div_req.den   = DAL_DEN_W'(m_eff);
                state_next    = ST_NET_DIV;
            end
            ST_NET_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (hi58 > 58'sd33554431)
                    begin
                        hi_next = 26'sd33554431;
                    end
                    else if (hi58 < -58'sd33554432)
                    begin
                        hi_next = -26'sd33554432;
                    end
                    else
                    begin
                        hi_next = hi58[25:0];
                    end
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = act_reg;
                    if (r2 > 26'sd131071)
                    begin
                        out_accel_next = 18'sd131071;
                    end
                    else if (r2 < -26'sd131072)
                    begin
                        out_accel_next = -18'sd131072;
                    end
                    else
                    begin
                        out_accel_next = r2[17:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            held_reg        <= '0;
            out_valid_reg   <= 1'b0;
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            gear_count_reg  <= DAL_RST_GEAR_COUNT;
            gear_ratios_reg <= DAL_RST_GEAR_RATIOS;
            axle_reg        <= DAL_RST_AXLE;
            wheel_reg       <= DAL_RST_WHEEL;
            mass_reg        <= DAL_RST_MASS;
            torque_reg      <= DAL_RST_TORQUE;
            window_reg      <= DAL_RST_WINDOW;
            resist_reg      <= DAL_RST_RESIST;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            if (cfg_valid)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_GEAR_COUNT:  gear_count_reg  <= cfg_data[3:0];
                    CFG_GEAR_RATIOS: gear_ratios_reg <= cfg_data;
                    CFG_AXLE_RATIO:  axle_reg        <= cfg_data[15:0];
                    CFG_WHEEL_DIAM:  wheel_reg       <= cfg_data[10:0];
                    CFG_MASS:        mass_reg        <= cfg_data[15:0];
                    CFG_MAX_TORQUE:  torque_reg      <= cfg_data[11:0];
                    CFG_RPM_WINDOW:  window_reg      <= cfg_data[31:0];
                    CFG_RESISTANCE:  resist_reg      <= cfg_data[47:0];
                    default:         gear_count_reg  <= gear_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        rf_reg        <= rf_next;
        act_reg       <= act_next;
        lo_reg        <= lo_next;
        tq4_reg       <= tq4_next;
        rden_reg      <= rden_next;
        g_reg         <= g_next;
        rpm_reg       <= rpm_next;
        best_reg      <= best_next;
        tq_reg        <= tq_next;
        base_reg      <= base_next;
        neg_reg       <= neg_next;
        span_reg      <= span_next;
        fw_reg        <= fw_next;
        hi_reg        <= hi_next;
        out_accel_reg <= out_accel_next;
        out_act_reg   <= out_act_next;
    end

endmodule

// ===== rtl/dal_checker.sv =====
// Port-level checks of the drivetrain acceleration limiter, bound to the top level.
// Depends on drivetrain_acceleration_limiter_core_assert.svh.
`include "drivetrain_acceleration_limiter_core_assert.svh"

module dal_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [17:0] limited_accel,
    input logic               acting_out
);
    `DAL_ASSERT_THEN(a_out_hold, out_valid && !out_ready, out_valid && $stable(limited_accel) && $stable(acting_out), "result dropped or changed while stalled")
    `DAL_ASSERT_THEN(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while another is in flight")
    `DAL_ASSERT_NOW(a_result_source, $rose(out_valid), !$past(in_ready), "result appeared with no request in flight")
endmodule

bind drivetrain_acceleration_limiter_core dal_checker u_dal_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .limited_accel (limited_accel),
    .acting_out    (acting_out)
);

// ===== tb/drivetrain_acceleration_limiter_core_test.sv =====
// Self-checking regression for the drivetrain acceleration limiter core.
// Depends on dal_pkg and the RTL of drivetrain_acceleration_limiter_core.
// A bit-true predictor scores every result against the accepted requests.
import dal_pkg::*;

typedef struct {
    logic signed [17:0] accel;
    logic               act;
} limited_t;

class dal_scoreboard;
    logic [3:0]         gear_count = DAL_RST_GEAR_COUNT;
    logic [63:0]        ratios     = DAL_RST_GEAR_RATIOS;
    logic [15:0]        axle       = DAL_RST_AXLE;
    logic [10:0]        wheel      = DAL_RST_WHEEL;
    logic [15:0]        mass       = DAL_RST_MASS;
    logic [11:0]        torque     = DAL_RST_TORQUE;
    logic [31:0]        window     = DAL_RST_WINDOW;
    logic [47:0]        resist     = DAL_RST_RESIST;
    logic signed [17:0] held       = '0;
    limited_t           expected_q[$];
    int                 failures   = 0;

    function void write_reg(cfg_index_t idx, logic [63:0] d);
        case (idx)
            CFG_GEAR_COUNT:  gear_count = d[3:0];
            CFG_GEAR_RATIOS: ratios     = d;
            CFG_AXLE_RATIO:  axle       = d[15:0];
            CFG_WHEEL_DIAM:  wheel      = d[10:0];
            CFG_MASS:        mass       = d[15:0];
            CFG_MAX_TORQUE:  torque     = d[11:0];
            CFG_RPM_WINDOW:  window     = d[31:0];
            CFG_RESISTANCE:  resist     = d[47:0];
            default: ;
        endcase
    endfunction

    function longint torque_at(longint rpm, longint sp[5], longint tq[5]);
        longint span;
        if (rpm <= sp[0]) return tq[0];
        if (rpm >= sp[4]) return tq[4];
        for (int i = 1; i < 5; i++) begin
            if (sp[i] >= rpm) begin
                span = sp[i] - sp[i-1];
                if (span <= 0) return tq[i];
                return tq[i-1] + ((tq[i] - tq[i-1]) * (rpm - sp[i-1])) / span;
            end
        end
        return tq[4];
    endfunction

    function longint accel_ceiling(longint unsigned v);
        longint unsigned d, m, rmin, rmax, t, n, g, rpm, q, best, den, fw, fa, drag, ax;
        longint sp[5], tq[5];
        longint roll, net;
        bit found;
        d    = (wheel != 0) ? wheel : 1;
        m    = (mass != 0) ? mass : 1;
        rmin = window[15:0];
        rmax = window[31:16];
        t    = torque;
        ax   = axle;
        n    = (gear_count > 8) ? 8 : gear_count;
        best = 0;
        found = 0;
        sp[0] = rmin; sp[1] = 1350; sp[2] = 4600; sp[3] = 5000; sp[4] = rmax;
        tq[0] = t * 128;
        tq[1] = t * 256; tq[2] = tq[1]; tq[3] = tq[1];
        tq[4] = (rmax != 0) ? (t * 256 * 5000) / rmax : 0;
        for (int i = 0; i < n; i++) begin
            g   = ratios[8*i +: 8];
            rpm = (v * ax * g * 64'd60000) / (64'd256 * 64'd205887 * d);
            if (rpm > rmax || rpm < rmin) continue;
            q = longint'(torque_at(rpm, sp, tq)) * g;
            if (!found || q > best) best = q;
            found = 1;
        end
        if (!found) return 9810;
        q    = best * ax;
        den  = 64'd131072 * d;
        fw   = (q / den) * 15625 + ((q % den) * 15625) / den;
        drag = resist[31:16];
        fa   = (64'd1000 * drag * v * v) >> 24;
        roll = resist[15:0];
        net  = longint'(fw) - longint'(fa);
        return net / longint'(m) - roll;
    endfunction

    function void note_request(logic act, logic signed [17:0] req, logic [15:0] v,
                               logic [9:0] rf);
        longint hi, lo, r;
        longint unsigned tf, rfu;
        limited_t e;
        if (act) held = req;
        hi  = accel_ceiling(v);
        tf  = resist[47:32];
        rfu = rf;
        lo  = -longint'((64'd9810 * rfu * tf) >> 16);
        r   = (held < hi) ? held : hi;
        if (r < lo) r = lo;
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        e.accel = r[17:0];
        e.act   = act;
        expected_q.insert(expected_q.size(), e);
    endfunction

    function void check_result(logic signed [17:0] accel, logic act);
        limited_t e;
        if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result accel=%0d acting=%0b", accel, act);
            return;
        end
        e = expected_q.pop_front();
        if (accel !== e.accel || act !== e.act) begin
            failures++;
            if (failures <= 10)
                $display("mismatch: expected accel=%0d acting=%0b, got accel=%0d acting=%0b",
                         e.accel, e.act, accel, act);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module drivetrain_acceleration_limiter_core_test;
    localparam int TOTAL_REQUESTS = 1750;
    localparam int CYCLE_LIMIT    = 12000000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               acting;
    logic signed [17:0] requested_accel;
    logic [15:0]        vehicle_speed;
    logic [9:0]         road_friction;
    logic               out_valid;
    logic               out_ready;
    logic signed [17:0] limited_accel;
    logic               acting_out;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;

    dal_scoreboard sb = new();
    int  sent = 0;
    bit  quiet = 0;
    int  long_hold = 0;
    int  cycles = 0;

    drivetrain_acceleration_limiter_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .acting(acting),
        .requested_accel(requested_accel), .vehicle_speed(vehicle_speed),
        .road_friction(road_friction),
        .out_valid(out_valid), .out_ready(out_ready), .limited_accel(limited_accel),
        .acting_out(acting_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_request(acting, requested_accel, vehicle_speed, road_friction);
        if (rst_n && out_valid && out_ready)
            sb.check_result(limited_accel, acting_out);
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int burst;
        bit stall;
        burst = 0;
        stall = 0;
        out_ready <= 0;
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                long_hold--;
                out_ready <= 0;
            end
            else if (quiet)
                out_ready <= 1;
            else
            begin
                if (burst == 0)
                begin
                    stall = ($urandom_range(0, 2) == 0);
                    burst = stall ? $urandom_range(1, 15) : $urandom_range(1, 40);
                end
                burst--;
                out_ready <= !stall;
            end
        end
    end

    task automatic send_request(logic a, logic signed [17:0] r, logic [15:0] v,
                                logic [9:0] f);
        in_valid        <= 1;
        acting          <= a;
        requested_accel <= r;
        vehicle_speed   <= v;
        road_friction   <= f;
        do @(posedge clk); while (!in_ready);
        sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_index_t idx, logic [63:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, d);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic load_profile(bit road_car, bit wild);
        logic [63:0] ratios;
        logic [15:0] lo_rpm, hi_rpm;
        for (int i = 0; i < 8; i++)
            ratios[8*i +: 8] = wild && $urandom_range(0, 3) == 0 ? 8'($urandom)
                                                                : 8'($urandom_range(8, 64));
        lo_rpm = $urandom_range(500, 1500);
        hi_rpm = $urandom_range(5000, 8000);
        if (road_car)
        begin
            write_reg(CFG_GEAR_COUNT, 6);
            write_reg(CFG_GEAR_RATIOS, 64'h0000_0A0D_1016_2238);
            write_reg(CFG_AXLE_RATIO, 15155);
            write_reg(CFG_WHEEL_DIAM, 650);
            write_reg(CFG_MASS, 1500);
            write_reg(CFG_MAX_TORQUE, 300);
            write_reg(CFG_RPM_WINDOW, {16'd6500, 16'd800});
            write_reg(CFG_RESISTANCE, {16'd256, 16'd77, 16'd100});
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: write_reg(CFG_GEAR_COUNT, 0);
                1: write_reg(CFG_GEAR_COUNT, 15);
                2: write_reg(CFG_GEAR_COUNT, 8);
                3: write_reg(CFG_GEAR_COUNT, 1);
                default: write_reg(CFG_GEAR_COUNT, $urandom_range(1, 8));
            endcase
            write_reg(CFG_GEAR_RATIOS, !wild ? ratios :
                      ($urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : ratios));
            write_reg(CFG_AXLE_RATIO, !wild ? $urandom_range(8000, 20000) :
                      ($urandom_range(0, 1) ? 16'hFFFF : 16'($urandom)));
            write_reg(CFG_WHEEL_DIAM, !wild ? $urandom_range(100, 2000) :
                      ($urandom_range(0, 1) ? 0 : 11'h7FF));
            write_reg(CFG_MASS, !wild ? $urandom_range(100, 5000) :
                      ($urandom_range(0, 1) ? 0 : 16'hFFFF));
            write_reg(CFG_MAX_TORQUE, !wild ? $urandom_range(50, 600) :
                      ($urandom_range(0, 1) ? 0 : 12'hFFF));
            case (wild ? $urandom_range(0, 3) : 3)
                0: write_reg(CFG_RPM_WINDOW, 32'hFFFF_FFFF);
                1: write_reg(CFG_RPM_WINDOW, {16'd0, 16'($urandom)});
                2: write_reg(CFG_RPM_WINDOW, {lo_rpm, hi_rpm});
                default: write_reg(CFG_RPM_WINDOW, {hi_rpm, lo_rpm});
            endcase
            write_reg(CFG_RESISTANCE, !wild ?
                      {16'($urandom_range(128, 400)), 16'($urandom_range(0, 200)),
                       16'($urandom_range(0, 500))} :
                      ($urandom_range(0, 1) ? 48'hFFFF_FFFF_FFFF : 48'($urandom) << 16));
        end
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic random_request();
        logic [15:0] v;
        logic [17:0] r;
        v = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12000));
        r = $urandom_range(0, 5) == 0 ? 18'($urandom) : 18'($urandom_range(0, 24000) - 12000);
        send_request($urandom_range(0, 2) != 0, r, v, 10'($urandom));
    endtask

    initial
    begin
        int per_phase;
        rst_n           <= 0;
        in_valid        <= 0;
        acting          <= 0;
        requested_accel <= '0;
        vehicle_speed   <= '0;
        road_friction   <= '0;
        cfg_valid       <= 0;
        cfg_index       <= CFG_GEAR_COUNT;
        cfg_data        <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset defaults: every gear ratio zero, so no gear fits
        send_request(0, 18'sd5000, 16'd0, 10'd0);
        send_request(1, 18'sh1FFFF, 16'hFFFF, 10'h3FF);
        send_request(1, -18'sh20000, 16'd2560, 10'd256);
        drain();

        load_profile(1, 0);
        send_request(0, 18'sd0, 16'd2560, 10'd256);
        send_request(1, 18'sh1FFFF, 16'd0, 10'd0);
        send_request(1, 18'sh1FFFF, 16'd768, 10'd256);
        send_request(1, 18'sh1FFFF, 16'd2560, 10'd256);
        send_request(1, 18'sh1FFFF, 16'd7680, 10'd256);
        send_request(1, 18'sh1FFFF, 16'hFFFF, 10'h3FF);
        send_request(0, 18'sd0, 16'd5120, 10'd128);
        send_request(1, -18'sh20000, 16'd2560, 10'h3FF);
        send_request(1, -18'sh20000, 16'd2560, 10'd0);
        send_request(0, 18'sd1234, 16'd12800, 10'd200);
        send_request(1, 18'sd2000, 16'd1000, 10'd300);
        send_request(1, -18'sd3000, 16'd4000, 10'd512);
        drain();

        per_phase = (TOTAL_REQUESTS - sent) / 10;
        for (int p = 0; p < 10; p++)
        begin
            load_profile(p == 9, p % 3 == 2);
            for (int k = 0; k < per_phase; k++)
            begin
                if (p == 1 && k == 20)
                    long_hold = 3000;
                if (p == 9 && k == per_phase / 2)
                    quiet = 1;
                random_request();
            end
            drain();
        end

        repeat (1500) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dal_pkg.sv
rtl/dal_mul.sv
rtl/dal_div.sv
rtl/drivetrain_acceleration_limiter_core.sv
rtl/dal_checker.sv
tb/drivetrain_acceleration_limiter_core_test.sv
